>>> sv/wpp_pkg.sv
`timescale 1ns / 1ps

package wpp_pkg;

	// Field widths
	localparam int CELL_LEFT_W  = 24;
	localparam int CELL_WIDTH_W = 20;
	localparam int PEN_W        = 48;
	localparam int CELLS_SEEN_W = 9;
	localparam int ROW_COUNT_W  = 3;
	localparam int ROW_END_W    = 23;
	localparam int CFG_INDEX_W  = 3;
	localparam int CFG_DATA_W   = ROW_END_W;

	// Internal arithmetic widths
	localparam int COORD_W  = CELL_LEFT_W + 2;  // left + width - other, signed
	localparam int CHARGE_W = COORD_W - 1;      // a positive charge or overlap

	// Defaults for the top level parameters
	localparam int DEF_MAX_CELLS = 256;
	localparam int DEF_MAX_ROWS  = 4;

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_ROW_COUNT = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_ROW_END_1 = 3'd1;

	localparam logic [PEN_W-1:0] PEN_MAX = {PEN_W{1'b1}};

	// One stored cell
	typedef struct packed {
		logic signed [CELL_LEFT_W-1:0] left;
		logic [CELL_WIDTH_W-1:0]       width;
	} cell_entry_t;

	// Saturating accumulate of a penalty
	function automatic logic [PEN_W-1:0] sat_add(input logic [PEN_W-1:0] acc,
			input logic [CHARGE_W-1:0] inc);
		logic [PEN_W:0] sum;
		sum = {1'b0, acc} + (PEN_W+1)'(inc);
		return sum[PEN_W] ? PEN_MAX : sum[PEN_W-1:0];
	endfunction

endpackage

>>> sv/window_placement_penalty.sv
`timescale 1ns / 1ps

// Penalty evaluation for one placement window. Cells arrive one per request
// (left edge on the unfolded row axis, width, last flag) and are taken one per
// cycle while loading; each is written to an on-chip cell memory and charged
// its bounds penalty on the way in. The request carrying last_cell starts the
// pairwise overlap sweep, during which cell_stall stays high. The sweep reads
// the single memory port once per pair; the result is registered once the sweep
// is done, both pipelines are empty and the output register is free. The result
// sits in an output register, so loading of the next window starts as soon as
// it is posted. Cells past MAX_CELLS are dropped, though a last cell still
// closes the window. Both penalties saturate at 2^48 - 1.
module window_placement_penalty
	import wpp_pkg::*;
#(
	parameter int MAX_CELLS = DEF_MAX_CELLS,
	parameter int MAX_ROWS  = DEF_MAX_ROWS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// cell requests
	input  logic                           cell_valid,
	output logic                           cell_stall,
	input  logic signed [CELL_LEFT_W-1:0]  cell_left,
	input  logic [CELL_WIDTH_W-1:0]        cell_width,
	input  logic                           last_cell,
	// result requests
	output logic                           res_valid,
	input  logic                           res_stall,
	output logic [PEN_W-1:0]               bounds_penalty,
	output logic [PEN_W-1:0]               overlap_penalty,
	output logic [CELLS_SEEN_W-1:0]        cells_seen,
	// configuration writes
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [CFG_INDEX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]          cfg_data
);

	localparam int AW  = $clog2(MAX_CELLS);
	localparam int CW  = $clog2(MAX_CELLS + 1);
	localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

	localparam logic [2:0] ST_LOAD  = 3'd0;
	localparam logic [2:0] ST_RD_I  = 3'd1;
	localparam logic [2:0] ST_LAT_I = 3'd2;
	localparam logic [2:0] ST_SWEEP = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;

	logic [2:0]             state_q;
	logic [CW-1:0]          cnt_q;
	logic [CW-1:0]          i_q;
	logic [CW-1:0]          j_q;

	logic [ROW_COUNT_W-1:0] row_count_q;
	logic [ROW_END_W-1:0]   row_end_q [MAX_ROWS];

	// bounds pipeline
	logic                          bnd_valid_s1;
	logic signed [CELL_LEFT_W-1:0] x_s1;
	logic [CELL_WIDTH_W-1:0]       w_s1;
	logic                          bnd_valid_s2;
	logic [CHARGE_W-1:0]           charge_s2;
	logic [PEN_W-1:0]              bounds_sum_q;

	// overlap pipeline
	cell_entry_t               rdata_q;
	cell_entry_t               cell_i_q;
	logic                      pair_s1;
	logic                      ov_valid_s2;
	logic [CHARGE_W-1:0]       ov_s2;
	logic [PEN_W-1:0]          ov_sum_q;

	// result register
	logic                      res_valid_q;
	logic [PEN_W-1:0]          res_bounds_q;
	logic [PEN_W-1:0]          res_overlap_q;
	logic [CELLS_SEEN_W-1:0]   res_cells_q;

	cell_entry_t mem [MAX_CELLS];

	logic          cell_acc;
	logic          store_en;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic          pipe_empty;
	logic          post_res;

	assign cell_stall = (state_q != ST_LOAD);
	assign cell_acc   = cell_valid && !cell_stall;
	assign store_en   = cell_acc && (cnt_q < CW'(MAX_CELLS));
	assign cfg_ready  = 1'b1;

	assign pipe_empty = !bnd_valid_s1 && !bnd_valid_s2 && !pair_s1 && !ov_valid_s2;
	assign post_res   = (state_q == ST_DRAIN) && pipe_empty && (!res_valid_q || !res_stall);

	// memory read port: cell i at the start of a row, cell j during the sweep
	assign mem_re    = (state_q == ST_RD_I) || (state_q == ST_SWEEP);
	assign mem_raddr = (state_q == ST_RD_I) ? i_q[AW-1:0] : j_q[AW-1:0];

	// cell memory
	always_ff @(posedge clk) begin
		if (store_en) begin
			mem[cnt_q[AW-1:0]] <= '{left: cell_left, width: cell_width};
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= ROW_COUNT_W'(1);
			for (int k = 0; k < MAX_ROWS; k++) begin
				row_end_q[k] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_ROW_COUNT) begin
				row_count_q <= cfg_data[ROW_COUNT_W-1:0];
			end
			for (int k = 0; k < MAX_ROWS; k++) begin
				if (cfg_index == CFG_INDEX_W'(CFG_ROW_END_1 + k)) begin
					row_end_q[k] <= cfg_data;
				end
			end
		end
	end

	// bounds charge of the cell in stage 1
	logic [ROW_COUNT_W-1:0]     rows_n;
	logic [RIW-1:0]             last_row;
	logic signed [COORD_W-1:0]  x_ext;
	logic signed [COORD_W-1:0]  w_ext;
	logic signed [COORD_W-1:0]  xw;
	logic signed [COORD_W-1:0]  end_ext;
	logic signed [COORD_W-1:0]  b_ext;
	logic signed [COORD_W-1:0]  right;
	logic signed [COORD_W-1:0]  leftpart;
	logic [CHARGE_W-1:0]        charge;
	logic                       found;

	always_comb begin
		rows_n = row_count_q;
		if (rows_n == '0) begin
			rows_n = ROW_COUNT_W'(1);
		end
		if (rows_n > ROW_COUNT_W'(MAX_ROWS)) begin
			rows_n = ROW_COUNT_W'(MAX_ROWS);
		end
		last_row = RIW'(rows_n - ROW_COUNT_W'(1));
		x_ext    = COORD_W'(x_s1);
		w_ext    = $signed(COORD_W'(w_s1));
		xw       = x_ext + w_ext;
		end_ext  = $signed(COORD_W'(row_end_q[last_row]));
		charge   = '0;
		found    = 1'b0;
		b_ext    = '0;
		right    = '0;
		leftpart = '0;
		if (x_ext < 0) begin
			charge = CHARGE_W'(-x_ext);
		end else if (xw > end_ext) begin
			charge = CHARGE_W'(xw - end_ext);
		end else begin
			// first row end that splits the cell, charged the smaller part
			for (int k = 0; k < MAX_ROWS; k++) begin
				b_ext = $signed(COORD_W'(row_end_q[k]));
				if (!found && (ROW_COUNT_W'(k) < rows_n) && (xw > b_ext) && (x_ext < b_ext)) begin
					found    = 1'b1;
					right    = xw - b_ext;
					leftpart = b_ext - x_ext;
					if ({right[COORD_W-2:0], 1'b0} > COORD_W'(w_s1)) begin
						charge = CHARGE_W'(leftpart);
					end else begin
						charge = CHARGE_W'(right);
					end
				end
			end
		end
	end

	// overlap of the held cell i and the cell j just read
	logic signed [COORD_W-1:0] xi_ext;
	logic signed [COORD_W-1:0] xj_ext;
	logic signed [COORD_W-1:0] reach;
	logic signed [COORD_W-1:0] diff;

	always_comb begin
		xi_ext = COORD_W'(cell_i_q.left);
		xj_ext = COORD_W'(rdata_q.left);
		// on a tie cell i came first and is the left cell
		if (xi_ext > xj_ext) begin
			reach = xj_ext + $signed(COORD_W'(rdata_q.width));
			diff  = reach - xi_ext;
		end else begin
			reach = xi_ext + $signed(COORD_W'(cell_i_q.width));
			diff  = reach - xj_ext;
		end
	end

	// pipelines and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bnd_valid_s1 <= 1'b0;
			bnd_valid_s2 <= 1'b0;
			pair_s1      <= 1'b0;
			ov_valid_s2  <= 1'b0;
			bounds_sum_q <= '0;
			ov_sum_q     <= '0;
		end else begin
			bnd_valid_s1 <= store_en;
			bnd_valid_s2 <= bnd_valid_s1;
			pair_s1      <= (state_q == ST_SWEEP);
			ov_valid_s2  <= pair_s1;
			if (post_res) begin
				bounds_sum_q <= '0;
				ov_sum_q     <= '0;
			end else begin
				if (bnd_valid_s2) begin
					bounds_sum_q <= sat_add(bounds_sum_q, charge_s2);
				end
				if (ov_valid_s2) begin
					ov_sum_q <= sat_add(ov_sum_q, ov_s2);
				end
			end
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (store_en) begin
			x_s1 <= cell_left;
			w_s1 <= cell_width;
		end
		charge_s2 <= charge;
		ov_s2     <= (diff > 0) ? CHARGE_W'(diff) : '0;
		if (state_q == ST_LAT_I) begin
			cell_i_q <= rdata_q;
		end
	end

	// sequencer: load, then one pair per cycle while in the sweep state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (store_en) begin
						cnt_q <= cnt_q + CW'(1);
					end
					if (cell_acc && last_cell) begin
						i_q     <= '0;
						state_q <= ST_RD_I;
					end
				end
				ST_RD_I: begin
					if (i_q + CW'(1) >= cnt_q) begin
						state_q <= ST_DRAIN;
					end else begin
						state_q <= ST_LAT_I;
					end
				end
				ST_LAT_I: begin
					j_q     <= i_q + CW'(1);
					state_q <= ST_SWEEP;
				end
				ST_SWEEP: begin
					if (j_q == cnt_q - CW'(1)) begin
						i_q     <= i_q + CW'(1);
						state_q <= ST_RD_I;
					end else begin
						j_q <= j_q + CW'(1);
					end
				end
				ST_DRAIN: begin
					if (post_res) begin
						cnt_q   <= '0;
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (post_res) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (post_res) begin
			res_bounds_q  <= bounds_sum_q;
			res_overlap_q <= ov_sum_q;
			res_cells_q   <= CELLS_SEEN_W'(cnt_q);
		end
	end

	assign res_valid       = res_valid_q;
	assign bounds_penalty  = res_bounds_q;
	assign overlap_penalty = res_overlap_q;
	assign cells_seen      = res_cells_q;

endmodule

>>> sv/wpp_checker.sv
`timescale 1ns / 1ps

module wpp_checker
	import wpp_pkg::*;
(
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cell_valid,
	input logic                          cell_stall,
	input logic signed [CELL_LEFT_W-1:0] cell_left,
	input logic [CELL_WIDTH_W-1:0]       cell_width,
	input logic                          last_cell,
	input logic                          res_valid,
	input logic                          res_stall,
	input logic [PEN_W-1:0]              bounds_penalty,
	input logic [PEN_W-1:0]              overlap_penalty,
	input logic [CELLS_SEEN_W-1:0]       cells_seen,
	input logic                          cfg_valid,
	input logic                          cfg_ready,
	input logic [CFG_INDEX_W-1:0]        cfg_index,
	input logic [CFG_DATA_W-1:0]         cfg_data
);

	// the last cell of a window closes the input for the overlap sweep
	a_last_closes_input: assert property (@(posedge clk) disable iff (!arst_n)
		(cell_valid && !cell_stall && last_cell) |=> cell_stall)
		else $error("input not stalled after last cell");

	// a result is only posted at the end of a sweep
	a_result_after_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(cell_stall))
		else $error("result posted while loading");

	// a stalled result holds
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=> (res_valid && $stable(bounds_penalty)
			&& $stable(overlap_penalty) && $stable(cells_seen)))
		else $error("stalled result changed");

endmodule

bind window_placement_penalty wpp_checker u_wpp_checker (.*);

>>> tb/window_placement_penalty_checker.sv
`timescale 1ns / 1ps

// Watches the cell, result and configuration channels of the penalty block,
// keeps its own copy of the window and of the row registers, and compares
// every result request with the penalties that the accepted cells call for.
module window_placement_penalty_checker
	import wpp_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cell_valid,
	input  logic                          cell_stall,
	input  logic signed [CELL_LEFT_W-1:0] cell_left,
	input  logic [CELL_WIDTH_W-1:0]       cell_width,
	input  logic                          last_cell,
	input  logic                          res_valid,
	input  logic                          res_stall,
	input  logic [PEN_W-1:0]              bounds_penalty,
	input  logic [PEN_W-1:0]              overlap_penalty,
	input  logic [CELLS_SEEN_W-1:0]       cells_seen,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [CFG_INDEX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data,
	output int                            fail_count,
	output int                            results_owed
);

	typedef struct packed {
		logic [PEN_W-1:0]        bounds;
		logic [PEN_W-1:0]        overlap;
		logic [CELLS_SEEN_W-1:0] seen;
	} window_result_t;

	window_result_t                owed_q[$];

	// shadow of the window being loaded
	logic signed [CELL_LEFT_W-1:0] left_mem [DEF_MAX_CELLS];
	logic [CELL_WIDTH_W-1:0]       width_mem [DEF_MAX_CELLS];
	logic [PEN_W-1:0]              bounds_acc;
	int                            stored;
	int                            fails;

	// shadow of the row registers
	logic [ROW_COUNT_W-1:0]        rows_reg;
	logic [ROW_END_W-1:0]          row_end_reg [DEF_MAX_ROWS];

	function automatic logic [PEN_W-1:0] pen_add(input logic [PEN_W-1:0] acc,
			input longint inc);
		longint total;
		total = longint'(acc) + inc;
		return (total > longint'(PEN_MAX)) ? PEN_MAX : total[PEN_W-1:0];
	endfunction

	// row count clamped to 1..MAX_ROWS
	function automatic int rows_in_use();
		int n;
		n = int'(rows_reg);
		if (n < 1)
			n = 1;
		if (n > DEF_MAX_ROWS)
			n = DEF_MAX_ROWS;
		return n;
	endfunction

	// bounds charge of one cell against the current row registers
	function automatic longint cell_charge(input longint x, input longint w);
		int     n;
		int     j;
		longint end_pos;
		longint bound;
		longint right_part;
		n = rows_in_use();
		end_pos = longint'(row_end_reg[n-1]);
		if (x < 0)
			return -x;
		if (x + w > end_pos)
			return x + w - end_pos;
		// first row end that cuts the cell: charge the smaller side
		for (j = 0; j < n; j++) begin
			bound = longint'(row_end_reg[j]);
			if (bound - w < x && x < bound) begin
				right_part = x + w - bound;
				if (2 * right_part > w)
					return bound - x;
				return right_part;
			end
		end
		return 0;
	endfunction

	// pairwise overlap, measured with the width of the leftmost cell
	function automatic logic [PEN_W-1:0] window_overlap();
		logic [PEN_W-1:0] sum;
		longint           xa;
		longint           xb;
		longint           lead_x;
		longint           lead_w;
		longint           trail_x;
		int               a;
		int               b;
		sum = '0;
		for (a = 0; a < stored; a++) begin
			for (b = a + 1; b < stored; b++) begin
				xa = longint'(left_mem[a]);
				xb = longint'(left_mem[b]);
				if (xa > xb) begin
					lead_x  = xb;
					lead_w  = longint'(width_mem[b]);
					trail_x = xa;
				end else begin
					lead_x  = xa;
					lead_w  = longint'(width_mem[a]);
					trail_x = xb;
				end
				if (lead_x + lead_w > trail_x)
					sum = pen_add(sum, lead_x + lead_w - trail_x);
			end
		end
		return sum;
	endfunction

	task automatic apply_reg();
		if (cfg_index == CFG_ROW_COUNT)
			rows_reg = cfg_data[ROW_COUNT_W-1:0];
		else if (cfg_index >= CFG_ROW_END_1 && cfg_index < CFG_ROW_END_1 + DEF_MAX_ROWS)
			row_end_reg[2'(cfg_index - CFG_ROW_END_1)] = cfg_data;
	endtask

	// store and charge a cell; a last cell closes the window
	task automatic take_cell();
		window_result_t r;
		if (stored < DEF_MAX_CELLS) begin
			left_mem[stored]  = cell_left;
			width_mem[stored] = cell_width;
			bounds_acc = pen_add(bounds_acc,
				cell_charge(longint'(cell_left), longint'(cell_width)));
			stored++;
		end
		if (last_cell) begin
			r.bounds  = bounds_acc;
			r.overlap = window_overlap();
			r.seen    = CELLS_SEEN_W'(stored);
			owed_q.push_back(r);
			bounds_acc = '0;
			stored     = 0;
		end
	endtask

	task automatic check_result();
		window_result_t want;
		if (owed_q.size() == 0) begin
			$error("result request with no window closed: bounds %0d overlap %0d cells %0d",
				bounds_penalty, overlap_penalty, cells_seen);
			fails++;
			return;
		end
		want = owed_q.pop_front();
		if (bounds_penalty !== want.bounds) begin
			$error("bounds_penalty expected %0d actual %0d", want.bounds, bounds_penalty);
			fails++;
		end
		if (overlap_penalty !== want.overlap) begin
			$error("overlap_penalty expected %0d actual %0d", want.overlap, overlap_penalty);
			fails++;
		end
		if (cells_seen !== want.seen) begin
			$error("cells_seen expected %0d actual %0d", want.seen, cells_seen);
			fails++;
		end
	endtask

	// follow every request as it is accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owed_q.delete();
			bounds_acc = '0;
			stored     = 0;
			fails      = 0;
			rows_reg   = ROW_COUNT_W'(1);
			foreach (row_end_reg[k])
				row_end_reg[k] = '0;
			fail_count   <= 0;
			results_owed <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				apply_reg();
			if (cell_valid && !cell_stall)
				take_cell();
			if (res_valid && !res_stall)
				check_result();
			fail_count   <= fails;
			results_owed <= owed_q.size();
		end
	end

endmodule

>>> tb/window_placement_penalty_test.sv
`timescale 1ns / 1ps

// Drives cell windows and register writes into the penalty block; the checker
// beside it predicts and compares, and this module gives the verdict.
module window_placement_penalty_test;
	import wpp_pkg::*;

	localparam int STALL_LIMIT    = 200000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int DRAIN_CYCLES   = 50;
	localparam int PHASE_ITEMS    = 350;
	localparam int WIDTH_LIMIT    = 1048575;

	localparam logic signed [CELL_LEFT_W-1:0] LEFT_MIN  = 24'h800000;
	localparam logic signed [CELL_LEFT_W-1:0] LEFT_MAX  = 24'h7FFFFF;
	localparam logic [CELL_WIDTH_W-1:0]       WIDTH_MAX = 20'hFFFFF;
	localparam logic [ROW_END_W-1:0]          END_MAX   = 23'h7FFFFF;
	localparam logic [CFG_INDEX_W-1:0]        CFG_FIRST_UNUSED = CFG_ROW_END_1 + 3'd4;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cell_valid = 1'b0;
	logic                          cell_stall;
	logic signed [CELL_LEFT_W-1:0] cell_left = '0;
	logic [CELL_WIDTH_W-1:0]       cell_width = '0;
	logic                          last_cell = 1'b0;
	logic                          res_valid;
	logic                          res_stall = 1'b0;
	logic [PEN_W-1:0]              bounds_penalty;
	logic [PEN_W-1:0]              overlap_penalty;
	logic [CELLS_SEEN_W-1:0]       cells_seen;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [CFG_INDEX_W-1:0]        cfg_index = '0;
	logic [CFG_DATA_W-1:0]         cfg_data = '0;

	int                            fail_count;
	int                            results_owed;
	int                            gap_pct = 33;
	int                            stall_pct = 46;
	int                            idle_cycles = 0;

	// row setting last programmed, used to aim cells at the row ends
	logic [ROW_END_W-1:0]          ends_now [DEF_MAX_ROWS];
	int                            rows_now = 1;

	window_placement_penalty i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cell_valid     (cell_valid),
		.cell_stall     (cell_stall),
		.cell_left      (cell_left),
		.cell_width     (cell_width),
		.last_cell      (last_cell),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.bounds_penalty (bounds_penalty),
		.overlap_penalty(overlap_penalty),
		.cells_seen     (cells_seen),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	window_placement_penalty_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cell_valid     (cell_valid),
		.cell_stall     (cell_stall),
		.cell_left      (cell_left),
		.cell_width     (cell_width),
		.last_cell      (last_cell),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.bounds_penalty (bounds_penalty),
		.overlap_penalty(overlap_penalty),
		.cells_seen     (cells_seen),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.fail_count     (fail_count),
		.results_owed   (results_owed)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// result side backpressure
	always @(posedge clk) begin
		res_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// no request of any kind for too long ends the run
	always @(posedge clk) begin
		if ((cell_valid && !cell_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("window_placement_penalty_test failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// one cell request, with random idle cycles ahead of it
	task automatic send_cell(input logic signed [CELL_LEFT_W-1:0] x,
			input logic [CELL_WIDTH_W-1:0] w, input logic last);
		while ($urandom_range(0, 99) < gap_pct) begin
			cell_valid <= 1'b0;
			@(posedge clk);
		end
		cell_valid <= 1'b1;
		cell_left  <= x;
		cell_width <= w;
		last_cell  <= last;
		do @(posedge clk); while (cell_stall);
	endtask

	// hold cells back until every window has reported and the block settles
	task automatic wait_quiet();
		cell_valid <= 1'b0;
		do @(posedge clk); while (results_owed != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic program_rows(input logic [ROW_COUNT_W-1:0] count,
			input logic [ROW_END_W-1:0] e1, input logic [ROW_END_W-1:0] e2,
			input logic [ROW_END_W-1:0] e3, input logic [ROW_END_W-1:0] e4);
		write_reg(CFG_ROW_COUNT, CFG_DATA_W'(count));
		write_reg(CFG_ROW_END_1, e1);
		write_reg(CFG_ROW_END_1 + 3'd1, e2);
		write_reg(CFG_ROW_END_1 + 3'd2, e3);
		write_reg(CFG_ROW_END_1 + 3'd3, e4);
		ends_now[0] = e1;
		ends_now[1] = e2;
		ends_now[2] = e3;
		ends_now[3] = e4;
		rows_now = (count == 0) ? 1 : (int'(count) > DEF_MAX_ROWS) ? DEF_MAX_ROWS : int'(count);
	endtask

	// mostly cells inside the window or across a row end, some pure noise
	function automatic void pick_cell(output logic signed [CELL_LEFT_W-1:0] x,
			output logic [CELL_WIDTH_W-1:0] w);
		int     kind;
		int     span;
		int     wmax;
		int     row;
		kind = $urandom_range(0, 9);
		span = int'(ends_now[rows_now-1]);
		wmax = span / 3 + 16;
		if (wmax > WIDTH_LIMIT)
			wmax = WIDTH_LIMIT;
		if (kind == 0) begin
			x = CELL_LEFT_W'($urandom);
			w = CELL_WIDTH_W'($urandom);
		end else begin
			w = CELL_WIDTH_W'($urandom_range(0, wmax));
			if (kind < 5) begin
				x = CELL_LEFT_W'($urandom_range(0, span));
			end else begin
				row = $urandom_range(0, rows_now - 1);
				x = CELL_LEFT_W'(longint'(ends_now[row]) - longint'($urandom_range(0, w + 1)));
			end
		end
	endfunction

	initial begin
		logic signed [CELL_LEFT_W-1:0] x;
		logic [CELL_WIDTH_W-1:0]       w;
		logic [ROW_END_W-1:0]          e [DEF_MAX_ROWS];
		int                            sent;
		int                            n;
		int                            windows;

		ends_now[0] = '0;
		ends_now[1] = '0;
		ends_now[2] = '0;
		ends_now[3] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// field extremes under the reset setting: one row ending at zero
		send_cell(LEFT_MIN, WIDTH_MAX, 1'b0);
		send_cell(LEFT_MAX, WIDTH_MAX, 1'b0);
		send_cell('0, '0, 1'b1);
		wait_quiet();

		// three rows: split cells, exact half split, beyond end, tied lefts
		program_rows(3'd3, 23'd1000, 23'd3000, 23'd6000, 23'd9000);
		send_cell(24'sd900, 20'd400, 1'b0);
		send_cell(24'sd950, 20'd100, 1'b0);
		send_cell(24'sd2990, 20'd20, 1'b0);
		send_cell(24'sd5900, 20'd200, 1'b0);
		send_cell(24'sd6000, 20'd0, 1'b0);
		send_cell(24'sd1100, 20'd300, 1'b0);
		send_cell(24'sd1100, 20'd50, 1'b0);
		send_cell(-24'sd5, 20'd10, 1'b1);
		wait_quiet();

		// row end moved while a window is half loaded
		send_cell(24'sd2900, 20'd200, 1'b0);
		send_cell(24'sd5950, 20'd100, 1'b0);
		wait_quiet();
		write_reg(CFG_ROW_END_1 + 3'd2, 23'd5000);
		ends_now[2] = 23'd5000;
		send_cell(24'sd4990, 20'd20, 1'b1);
		wait_quiet();

		// row count zero acts as one; writes to unused indexes change nothing
		write_reg(CFG_ROW_COUNT, '0);
		write_reg(CFG_FIRST_UNUSED, 23'd77);
		write_reg(CFG_FIRST_UNUSED + 3'd1, END_MAX);
		write_reg(CFG_FIRST_UNUSED + 3'd2, 23'd12345);
		rows_now = 1;
		send_cell(24'sd990, 20'd20, 1'b0);
		send_cell(24'sd500, 20'd600, 1'b1);
		wait_quiet();

		// row count above the maximum, unsorted row ends, single cell window
		program_rows(3'd7, 23'd8000, 23'd500, END_MAX, 23'd4000);
		send_cell(24'sd450, 20'd100, 1'b0);
		send_cell(24'sd3000, 20'd2000, 1'b0);
		send_cell(24'sd7990, 20'd20, 1'b1);
		send_cell(24'sd100, 20'd50, 1'b1);

		// random windows, three idle patterns, a new row setting in each
		for (int phase = 0; phase < 3; phase++) begin
			wait_quiet();
			if (phase == 0) begin
				gap_pct   = 33;
				stall_pct = 46;
				e[0] = ROW_END_W'($urandom_range(500, 5000));
				for (int k = 1; k < DEF_MAX_ROWS; k++)
					e[k] = e[k-1] + ROW_END_W'($urandom_range(500, 5000));
				program_rows(3'd4, e[0], e[1], e[2], e[3]);
			end else if (phase == 1) begin
				gap_pct   = 46;
				stall_pct = 33;
				program_rows(3'd2, ROW_END_W'($urandom_range(1000000, 7000000)), END_MAX,
					'0, '0);
			end else begin
				gap_pct   = 0;
				stall_pct = 0;
				e[0] = ROW_END_W'($urandom_range(0, 15000));
				for (int k = 1; k < DEF_MAX_ROWS; k++)
					e[k] = e[k-1] + ROW_END_W'($urandom_range(0, 15000));
				program_rows(ROW_COUNT_W'($urandom_range(0, 7)), e[0], e[1], e[2], e[3]);
			end
			sent    = 0;
			windows = 0;
			while (sent < PHASE_ITEMS) begin
				// one overflowing window, one exactly full, the rest small
				if (phase == 0 && windows == 1)
					n = DEF_MAX_CELLS + $urandom_range(1, 4);
				else if (phase == 1 && windows == 2)
					n = DEF_MAX_CELLS;
				else if ($urandom_range(0, 9) == 0)
					n = $urandom_range(13, 40);
				else
					n = $urandom_range(1, 12);
				for (int i = 0; i < n; i++) begin
					pick_cell(x, w);
					send_cell(x, w, i == n - 1);
				end
				sent += n;
				windows++;
				if ($urandom_range(0, 7) == 0)
					wait_quiet();
			end
		end

		// let the last windows report
		cell_valid <= 1'b0;
		do @(posedge clk); while (results_owed != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("window_placement_penalty_test passed");
		else
			$display("window_placement_penalty_test failed");
		$finish;
	end

endmodule

>>> window_placement_penalty.f
sv/wpp_pkg.sv
sv/window_placement_penalty.sv
sv/wpp_checker.sv
tb/window_placement_penalty_checker.sv
tb/window_placement_penalty_test.sv
